// ----- src/rsdt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsdt_pkg - shared types and constants of the sorted device table
// Field widths of the item ports, function codes, default sizes and the
// control struct that the table row hands to each cell.
// ----------------------------------------------------------------------------
package rsdt_pkg;

	localparam int STRENGTH_W = 8;
	localparam int ADDR_PORT_W = 48;
	localparam int RANK_W = 5;
	localparam int HELD_W = 6;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam int DEF_ADDR_BYTES = 6;

	localparam logic FUNC_REPORT = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic sample;
		logic update;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/rssi_sorted_device_table_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rssi_sorted_device_table_unit - device table kept sorted by signal strength
// Report items update or append a device (a new one is dropped when full) and keep
// the table stably ranked, strongest first; read items return the device at a rank.
// ----------------------------------------------------------------------------
// In the cycle of an item's transfer each cell of the
// row matches the report address and compares its strength with the report;
// once the output register can take the result, every cell loads its own
// entry, a neighbor's entry or the new entry at once, and the result goes to
// the output register. The row of cells handles one item at a time, so it
// takes no new item until the last one is done; a result left waiting holds
// back the update of the following item. No clearing pass is needed after reset.
module rssi_sorted_device_table_unit import rsdt_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int ADDR_BYTES = DEF_ADDR_BYTES
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic [ADDR_PORT_W-1:0]       report_addr,
	input  wire logic signed [STRENGTH_W-1:0] report_strength,
	input  wire logic [RANK_W-1:0]            read_rank,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              entry_present,
	output logic [ADDR_PORT_W-1:0]            entry_addr,
	output logic signed [STRENGTH_W-1:0]      entry_strength,
	output logic [HELD_W-1:0]                 devices_held,
	output logic                              was_new,
	output logic                              was_dropped
);

	localparam int AW = ADDR_BYTES * 8;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	logic                         accept;
	logic                         done;
	logic                         busy_s1;
	logic                         func_s1;
	logic [AW-1:0]                addr_s1;
	logic signed [STRENGTH_W-1:0] str_s1;
	logic [RANK_W-1:0]            rank_s1;
	logic [CNT_W-1:0]             fill_q;
	logic [AW-1:0]                cmp_addr;
	cell_ctl_t                    ctl;

	logic [AW-1:0]                cell_addr [TABLE_DEPTH];
	logic signed [STRENGTH_W-1:0] cell_str [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]       cell_ahead;
	logic [TABLE_DEPTH-1:0]       hit_vec;

	logic                         hit_any;
	logic [IDX_W-1:0]             k_hit;
	logic [CNT_W-1:0]             k;
	logic                         full;
	logic                         is_new;
	logic                         dropped;
	logic [CNT_W-1:0]             fill_nxt;
	logic [CMP_W-1:0]             rank_ext;
	logic                         present;
	logic [IDX_W-1:0]             rank_idx;

	logic                         out_valid_q;
	logic                         present_q;
	logic [ADDR_PORT_W-1:0]       raddr_q;
	logic signed [STRENGTH_W-1:0] rstr_q;
	logic [HELD_W-1:0]            held_q;
	logic                         new_q;
	logic                         dropped_q;

	assign in_ready = ~busy_s1;
	assign accept = in_valid & in_ready;
	assign done = busy_s1 & (~out_valid_q | out_ready);
	assign cmp_addr = AW'(report_addr);

	always_comb begin
		k_hit = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit_vec[i]) begin
				k_hit = k_hit | IDX_W'(i);
			end
		end
	end

	assign hit_any = |hit_vec;
	assign k = hit_any ? CNT_W'(k_hit) : fill_q;
	assign full = fill_q == CNT_W'(TABLE_DEPTH);
	assign is_new = (func_s1 == FUNC_REPORT) & ~hit_any & ~full;
	assign dropped = (func_s1 == FUNC_REPORT) & ~hit_any & full;
	assign fill_nxt = is_new ? fill_q + CNT_W'(1) : fill_q;

	assign ctl.sample = accept;
	assign ctl.update = done & (func_s1 == FUNC_REPORT) & ~dropped;

	assign rank_ext = CMP_W'(rank_s1);
	assign present = (func_s1 == FUNC_READ) & (rank_ext < CMP_W'(fill_q));
	assign rank_idx = rank_ext[IDX_W-1:0];

	generate
		for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			logic [AW-1:0]                up_addr;
			logic signed [STRENGTH_W-1:0] up_str;
			logic                         up_ahead;
			logic [AW-1:0]                dn_addr;
			logic signed [STRENGTH_W-1:0] dn_str;
			logic                         dn_ahead;

			if (g == 0) begin : g_top
				assign up_addr = '0;
				assign up_str = '0;
				assign up_ahead = 1'b1;
			end else begin : g_mid
				assign up_addr = cell_addr[g-1];
				assign up_str = cell_str[g-1];
				assign up_ahead = cell_ahead[g-1];
			end

			if (g == TABLE_DEPTH - 1) begin : g_end
				assign dn_addr = '0;
				assign dn_str = '0;
				assign dn_ahead = 1'b0;
			end else begin : g_inner
				assign dn_addr = cell_addr[g+1];
				assign dn_str = cell_str[g+1];
				assign dn_ahead = cell_ahead[g+1];
			end

			rsdt_cell #(
				.IDX   (g),
				.AW    (AW),
				.CNT_W (CNT_W)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.cmp_addr (cmp_addr),
				.cmp_str  (report_strength),
				.new_addr (addr_s1),
				.new_str  (str_s1),
				.k        (k),
				.fill     (fill_q),
				.up_addr  (up_addr),
				.up_str   (up_str),
				.up_ahead (up_ahead),
				.dn_addr  (dn_addr),
				.dn_str   (dn_str),
				.dn_ahead (dn_ahead),
				.addr     (cell_addr[g]),
				.str      (cell_str[g]),
				.ahead    (cell_ahead[g]),
				.hit      (hit_vec[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				fill_q <= fill_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			addr_s1 <= cmp_addr;
			str_s1 <= report_strength;
			rank_s1 <= read_rank;
		end
		if (done) begin
			present_q <= present;
			raddr_q <= present ? ADDR_PORT_W'(cell_addr[rank_idx]) : '0;
			rstr_q <= present ? cell_str[rank_idx] : '0;
			held_q <= HELD_W'(fill_nxt);
			new_q <= is_new;
			dropped_q <= dropped;
		end
	end

	assign out_valid = out_valid_q;
	assign entry_present = present_q;
	assign entry_addr = raddr_q;
	assign entry_strength = rstr_q;
	assign devices_held = held_q;
	assign was_new = new_q;
	assign was_dropped = dropped_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> $onehot0(hit_vec))
		else $error("report address matched more than one entry");

	a_new_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(new_q && dropped_q))
		else $error("report both added and dropped");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !present_q) |-> (raddr_q == '0 && rstr_q == '0))
		else $error("absent entry carries data");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(fill_q))
		else $error("fill count moved outside an update");

endmodule
`default_nettype wire

// ----- src/rsdt_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsdt_cell - one rank of the sorted device table
// Holds the entry at its rank, matches the report address and compares
// strengths, then takes its own, its neighbor's or the new entry on update.
// ----------------------------------------------------------------------------
module rsdt_cell import rsdt_pkg::*; #(
	parameter int IDX = 0,
	parameter int AW = DEF_ADDR_BYTES * 8,
	parameter int CNT_W = $clog2(DEF_TABLE_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire cell_ctl_t                    ctl,
	input  wire logic [AW-1:0]                cmp_addr,
	input  wire logic signed [STRENGTH_W-1:0] cmp_str,
	input  wire logic [AW-1:0]                new_addr,
	input  wire logic signed [STRENGTH_W-1:0] new_str,
	input  wire logic [CNT_W-1:0]             k,
	input  wire logic [CNT_W-1:0]             fill,
	input  wire logic [AW-1:0]                up_addr,
	input  wire logic signed [STRENGTH_W-1:0] up_str,
	input  wire logic                         up_ahead,
	input  wire logic [AW-1:0]                dn_addr,
	input  wire logic signed [STRENGTH_W-1:0] dn_str,
	input  wire logic                         dn_ahead,
	output logic [AW-1:0]                     addr,
	output logic signed [STRENGTH_W-1:0]      str,
	output logic                              ahead,
	output logic                              hit
);

	logic [AW-1:0]                addr_q;
	logic signed [STRENGTH_W-1:0] str_q;
	logic                         hit_q;
	logic                         ge_q;
	logic                         gt_q;
	logic                         valid;
	logic                         lt;
	logic                         eq;
	logic [AW-1:0]                addr_nxt;
	logic signed [STRENGTH_W-1:0] str_nxt;

	assign valid = CNT_W'(IDX) < fill;
	assign lt = CNT_W'(IDX) < k;
	assign eq = CNT_W'(IDX) == k;
	assign ahead = valid & ~eq & (lt ? ge_q : gt_q);

	always_comb begin
		addr_nxt = addr_q;
		str_nxt = str_q;
		if (lt) begin
			if (ahead) begin
				addr_nxt = addr_q;
				str_nxt = str_q;
			end else if (up_ahead) begin
				addr_nxt = new_addr;
				str_nxt = new_str;
			end else begin
				addr_nxt = up_addr;
				str_nxt = up_str;
			end
		end else if (eq) begin
			if (dn_ahead) begin
				addr_nxt = dn_addr;
				str_nxt = dn_str;
			end else if (up_ahead) begin
				addr_nxt = new_addr;
				str_nxt = new_str;
			end else begin
				addr_nxt = up_addr;
				str_nxt = up_str;
			end
		end else begin
			if (dn_ahead) begin
				addr_nxt = dn_addr;
				str_nxt = dn_str;
			end else if (ahead) begin
				addr_nxt = new_addr;
				str_nxt = new_str;
			end
		end
	end

	// compare at transfer time, against the table as it stands
	always_ff @(posedge clk) begin
		if (ctl.sample) begin
			hit_q <= valid & (addr_q == cmp_addr);
			ge_q <= str_q >= cmp_str;
			gt_q <= str_q > cmp_str;
		end
		if (ctl.update) begin
			addr_q <= addr_nxt;
			str_q <= str_nxt;
		end
	end

	assign addr = addr_q;
	assign str = str_q;
	assign hit = hit_q;

endmodule
`default_nettype wire
